@@ hw/rtl/qat_pkg.sv @@
// Shared types, constants and helper functions for the quoted argument tokenizer.
package qat_pkg;

  // Configuration port geometry and register map.
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;
  localparam logic REG_MAX_FIELDS = 1'b0;
  localparam logic [7:0] MAX_FIELDS_RESET = 8'd16;

  // Byte values with a special meaning in the line.
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END  = 2'd1,
    KIND_DONE = 2'd2,
    KIND_OVER = 2'd3
  } kind_t;

  // Quote state of the line.
  typedef enum logic [1:0] {
    QUOTE_NONE   = 2'd0,
    QUOTE_SINGLE = 2'd1,
    QUOTE_DOUBLE = 2'd2
  } quote_t;

  // One input request.
  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_line;
  } in_item_t;

  // One result request.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] out_char;
    logic [7:0] token_index;
    logic [7:0] token_count;
    logic       last;
  } out_item_t;

  // Line state carried from one byte to the next.
  typedef struct packed {
    quote_t     quote_mode;
    logic       in_token;
    logic       escape_pending;
    logic [7:0] token_total;
    logic       line_finished;
  } line_state_t;

  localparam line_state_t LINE_STATE_CLEAR = '{
    quote_mode:     QUOTE_NONE,
    in_token:       1'b0,
    escape_pending: 1'b0,
    token_total:    8'd0,
    line_finished:  1'b0
  };

  // Space, tab, newline, vertical tab, form feed and carriage return.
  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) ||
           (c == 8'h0B) || (c == 8'h0C) || (c == 8'h0D);
  endfunction

endpackage

@@ hw/rtl/qat_step.sv @@
// Combinational tokenizer step: one byte and the line state in, up to four results out.
module qat_step (
  input  qat_pkg::in_item_t    item,
  input  qat_pkg::line_state_t st,
  input  logic [7:0]           max_fields,
  output qat_pkg::line_state_t st_nxt,
  output qat_pkg::out_item_t   res [4],
  output logic [2:0]           res_cnt
);

  // Results land in fixed slots: escaped backslash, byte or token end,
  // token end at line end, and the line result.
  qat_pkg::out_item_t slots [4];
  logic [3:0] slot_en;
  logic       do_fin;
  logic       do_tok;
  logic       set_skip;
  logic       quote_char;
  qat_pkg::quote_t quote_of_char;
  logic [7:0] tok_idx;
  logic [2:0] n;

  always_comb begin
    st_nxt = st;
    slot_en = '0;
    for (int s = 0; s < 4; s++) begin
      slots[s] = '0;
    end
    do_fin = 1'b0;
    do_tok = 1'b0;
    set_skip = 1'b0;
    quote_char = (item.ch == qat_pkg::CH_DQUOTE) || (item.ch == qat_pkg::CH_SQUOTE);
    quote_of_char = (item.ch == qat_pkg::CH_SQUOTE) ? qat_pkg::QUOTE_SINGLE
                                                    : qat_pkg::QUOTE_DOUBLE;
    tok_idx = '0;

    // Top-level decision on the byte.
    if (st.line_finished) begin
      if ((item.ch == qat_pkg::CH_NUL) || item.end_of_line) begin
        st_nxt = qat_pkg::LINE_STATE_CLEAR;
      end
    end else if (st.escape_pending) begin
      st_nxt.escape_pending = 1'b0;
      if (item.ch == qat_pkg::CH_NUL) begin
        do_fin = 1'b1;
      end else begin
        tok_idx = st.token_total - 8'd1;
        if (!(quote_char || (item.ch == qat_pkg::CH_BACKSLASH) ||
              qat_pkg::is_space(item.ch))) begin
          slot_en[0] = 1'b1;
          slots[0].kind = qat_pkg::KIND_BYTE;
          slots[0].out_char = qat_pkg::CH_BACKSLASH;
          slots[0].token_index = tok_idx;
        end
        slot_en[1] = 1'b1;
        slots[1].kind = qat_pkg::KIND_BYTE;
        slots[1].out_char = item.ch;
        slots[1].token_index = tok_idx;
        do_fin = item.end_of_line;
      end
    end else if (item.ch == qat_pkg::CH_NUL) begin
      do_fin = 1'b1;
    end else if (!st.in_token) begin
      if (item.ch == qat_pkg::CH_NEWLINE) begin
        do_fin = 1'b1;
        set_skip = !item.end_of_line;
      end else if (qat_pkg::is_space(item.ch)) begin
        do_fin = item.end_of_line;
      end else if (st.token_total >= max_fields) begin
        slot_en[3] = 1'b1;
        slots[3].kind = qat_pkg::KIND_OVER;
        st_nxt = qat_pkg::LINE_STATE_CLEAR;
        st_nxt.line_finished = !item.end_of_line;
      end else begin
        st_nxt.token_total = st.token_total + 8'd1;
        st_nxt.in_token = 1'b1;
        do_tok = 1'b1;
        do_fin = item.end_of_line;
      end
    end else begin
      do_tok = 1'b1;
      do_fin = item.end_of_line;
    end

    // Ordinary byte inside a token.
    if (do_tok) begin
      tok_idx = st_nxt.token_total - 8'd1;
      if ((st.quote_mode == qat_pkg::QUOTE_NONE) && qat_pkg::is_space(item.ch)) begin
        slot_en[1] = 1'b1;
        slots[1].kind = qat_pkg::KIND_END;
        slots[1].token_index = tok_idx;
        st_nxt.in_token = 1'b0;
      end else if (quote_char) begin
        if (st.quote_mode == qat_pkg::QUOTE_NONE) begin
          st_nxt.quote_mode = quote_of_char;
        end else if (st.quote_mode == quote_of_char) begin
          st_nxt.quote_mode = qat_pkg::QUOTE_NONE;
        end else begin
          slot_en[1] = 1'b1;
          slots[1].kind = qat_pkg::KIND_BYTE;
          slots[1].out_char = item.ch;
          slots[1].token_index = tok_idx;
        end
      end else if (item.ch == qat_pkg::CH_BACKSLASH) begin
        st_nxt.escape_pending = 1'b1;
      end else begin
        slot_en[1] = 1'b1;
        slots[1].kind = qat_pkg::KIND_BYTE;
        slots[1].out_char = item.ch;
        slots[1].token_index = tok_idx;
      end
    end

    // Line end: close an open token, give the line result, clear the line.
    if (do_fin) begin
      if (st_nxt.in_token) begin
        slot_en[2] = 1'b1;
        slots[2].kind = qat_pkg::KIND_END;
        slots[2].token_index = st_nxt.token_total - 8'd1;
      end
      slot_en[3] = 1'b1;
      if (st_nxt.token_total >= max_fields) begin
        slots[3].kind = qat_pkg::KIND_OVER;
      end else begin
        slots[3].kind = qat_pkg::KIND_DONE;
        slots[3].token_count = st_nxt.token_total;
      end
      st_nxt = qat_pkg::LINE_STATE_CLEAR;
      st_nxt.line_finished = set_skip;
    end
  end

  // Pack the enabled slots in order and flag the final one.
  always_comb begin
    n = '0;
    for (int k = 0; k < 4; k++) begin
      res[k] = '0;
    end
    for (int s = 0; s < 4; s++) begin
      if (slot_en[s]) begin
        res[n[1:0]] = slots[s];
        n = n + 3'd1;
      end
    end
    for (int k = 0; k < 4; k++) begin
      res[k].last = (3'(k) == (n - 3'd1));
    end
    res_cnt = n;
  end

endmodule

@@ hw/rtl/quoted_argument_tokenizer.sv @@
// Top level of the quoted argument tokenizer: handshakes, registers and result buffer.
//
//   Channel  Ports                          Moves
//   in       in_valid, in_ready, in_data    one line byte and its end flag per request
//   out      out_valid, out_ready, out_data one result per request
//   cfg      cfg_psel ... cfg_pready        APB-style access to max_fields
//
// A byte is captured in an input register, decoded by the step logic and its
// results are loaded into a four-entry result buffer that drives out_data.
// The rate is one byte per cycle while each byte gives at most one result and
// out_ready is high; a byte giving n results holds the result buffer until all
// n are taken. Bytes giving no result do not occupy the result buffer. Reset
// clears the line state and sets max_fields to 16. Backpressure on out_ready
// stalls the input register, then in_ready.
module quoted_argument_tokenizer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  qat_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output qat_pkg::out_item_t            out_data,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [qat_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [qat_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [qat_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                          cfg_pready
);

  qat_pkg::in_item_t    in_data_r;
  logic                 in_valid_r;
  qat_pkg::line_state_t st_r;
  qat_pkg::line_state_t st_nxt;
  logic [7:0]           max_fields_r;
  qat_pkg::out_item_t   res_r [4];
  qat_pkg::out_item_t   step_res [4];
  logic [2:0]           step_cnt;
  logic [2:0]           res_cnt_r;
  logic [1:0]           res_pos_r;
  logic                 buf_busy;
  logic                 drain_last;
  logic                 advance;
  logic                 cfg_sel_max;

  // Configuration register access.
  assign cfg_pready = 1'b1;
  assign cfg_sel_max = (cfg_paddr[2] == qat_pkg::REG_MAX_FIELDS);
  assign cfg_prdata = cfg_sel_max ? {24'd0, max_fields_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_fields_r <= qat_pkg::MAX_FIELDS_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_sel_max) begin
      max_fields_r <= cfg_pwdata[7:0];
    end
  end

  // Result buffer occupancy and hand-off from the input register.
  assign buf_busy = (res_cnt_r != 3'd0);
  assign drain_last = buf_busy && out_ready && ({1'b0, res_pos_r} == (res_cnt_r - 3'd1));
  assign advance = in_valid_r && (!buf_busy || drain_last);
  assign in_ready = !in_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  // Per-byte decode.
  qat_step u_step (
    .item       (in_data_r),
    .st         (st_r),
    .max_fields (max_fields_r),
    .st_nxt     (st_nxt),
    .res        (step_res),
    .res_cnt    (step_cnt)
  );

  // Line state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= qat_pkg::LINE_STATE_CLEAR;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // Result buffer control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_cnt_r <= 3'd0;
      res_pos_r <= 2'd0;
    end else if (advance) begin
      res_cnt_r <= step_cnt;
      res_pos_r <= 2'd0;
    end else if (drain_last) begin
      res_cnt_r <= 3'd0;
      res_pos_r <= 2'd0;
    end else if (buf_busy && out_ready) begin
      res_pos_r <= res_pos_r + 2'd1;
    end
  end

  // Result buffer payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k < 4; k++) begin
        res_r[k] <= step_res[k];
      end
    end
  end

  assign out_valid = buf_busy;
  assign out_data = res_r[res_pos_r];

endmodule

@@ tb/sv/tb_quoted_argument_tokenizer.sv @@
// Self-checking testbench for the quoted argument tokenizer: line stimulus, prediction, checks.
`timescale 1ns / 100ps

module tb_quoted_argument_tokenizer;

  // Whitespace bytes besides the newline.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_VTAB = 8'h0B;
  localparam logic [7:0] CH_FORMFEED = 8'h0C;
  localparam logic [7:0] CH_RETURN = 8'h0D;

  localparam int unsigned ADDR_W = qat_pkg::CFG_AW;
  localparam int unsigned DATA_W = qat_pkg::CFG_DW;
  localparam logic [ADDR_W-1:0] MAX_FIELDS_ADDR = ADDR_W'(4 * qat_pkg::REG_MAX_FIELDS);
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 200;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_BYTES = 135;

  // Predicts the token stream of each byte and checks the results in order.
  class token_scoreboard;
    logic [7:0]         max_fields;
    qat_pkg::quote_t    quote_mode;
    logic               in_token;
    logic               escape_pending;
    logic [7:0]         token_total;
    logic               line_finished;
    qat_pkg::out_item_t expected_q[$];
    int                 mismatches;
    int                 bytes_used;

    function new();
      max_fields = qat_pkg::MAX_FIELDS_RESET;
      mismatches = 0;
      bytes_used = 0;
      clear_line();
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void clear_line();
      quote_mode = qat_pkg::QUOTE_NONE;
      in_token = 1'b0;
      escape_pending = 1'b0;
      token_total = 8'd0;
      line_finished = 1'b0;
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == qat_pkg::CH_NEWLINE || c == CH_VTAB ||
             c == CH_FORMFEED || c == CH_RETURN;
    endfunction

    function void add_result(qat_pkg::kind_t k, logic [7:0] c, logic [7:0] idx,
                             logic [7:0] cnt);
      qat_pkg::out_item_t r;
      r.kind = k;
      r.out_char = c;
      r.token_index = idx;
      r.token_count = cnt;
      r.last = 1'b0;
      expected_q.push_back(r);
    endfunction

    function void emit_char(logic [7:0] c);
      add_result(qat_pkg::KIND_BYTE, c, token_total - 8'd1, 8'd0);
    endfunction

    // Close an open token, then report the count or the overflow.
    function void finish_line();
      if (in_token) add_result(qat_pkg::KIND_END, 8'd0, token_total - 8'd1, 8'd0);
      if (token_total >= max_fields) add_result(qat_pkg::KIND_OVER, 8'd0, 8'd0, 8'd0);
      else add_result(qat_pkg::KIND_DONE, 8'd0, 8'd0, token_total);
      clear_line();
    endfunction

    // A non-zero byte inside a token that does not follow a backslash.
    function void token_char(logic [7:0] c);
      qat_pkg::quote_t q;
      if (quote_mode == qat_pkg::QUOTE_NONE && is_blank(c)) begin
        add_result(qat_pkg::KIND_END, 8'd0, token_total - 8'd1, 8'd0);
        in_token = 1'b0;
      end else if (c == qat_pkg::CH_DQUOTE || c == qat_pkg::CH_SQUOTE) begin
        q = (c == qat_pkg::CH_SQUOTE) ? qat_pkg::QUOTE_SINGLE : qat_pkg::QUOTE_DOUBLE;
        if (quote_mode == qat_pkg::QUOTE_NONE) quote_mode = q;
        else if (quote_mode == q) quote_mode = qat_pkg::QUOTE_NONE;
        else emit_char(c);
      end else if (c == qat_pkg::CH_BACKSLASH) begin
        escape_pending = 1'b1;
      end else begin
        emit_char(c);
      end
    endfunction

    // Work out the results of one accepted input request.
    function void note_byte(qat_pkg::in_item_t item);
      logic [7:0]         c;
      logic               eol;
      int                 first;
      qat_pkg::out_item_t r;
      c = item.ch;
      eol = item.end_of_line;
      first = expected_q.size();
      // The rest of a finished line is skipped silently.
      if (line_finished) begin
        if (c == qat_pkg::CH_NUL || eol) clear_line();
        return;
      end
      bytes_used++;
      if (escape_pending) begin
        escape_pending = 1'b0;
        if (c == qat_pkg::CH_NUL) begin
          finish_line();
        end else begin
          if (!(c == qat_pkg::CH_DQUOTE || c == qat_pkg::CH_SQUOTE ||
                c == qat_pkg::CH_BACKSLASH || is_blank(c)))
            emit_char(qat_pkg::CH_BACKSLASH);
          emit_char(c);
          if (eol) finish_line();
        end
      end else if (c == qat_pkg::CH_NUL) begin
        finish_line();
      end else if (!in_token) begin
        if (c == qat_pkg::CH_NEWLINE) begin
          finish_line();
          if (!eol) line_finished = 1'b1;
        end else if (is_blank(c)) begin
          if (eol) finish_line();
        end else if (token_total >= max_fields) begin
          add_result(qat_pkg::KIND_OVER, 8'd0, 8'd0, 8'd0);
          clear_line();
          if (!eol) line_finished = 1'b1;
        end else begin
          token_total++;
          in_token = 1'b1;
          token_char(c);
          if (eol) finish_line();
        end
      end else begin
        token_char(c);
        if (eol) finish_line();
      end
      // Flag the final result of this byte.
      if (expected_q.size() > first) begin
        r = expected_q.pop_back();
        r.last = 1'b1;
        expected_q.push_back(r);
      end
    endfunction

    task report_mismatch(string what);
      if (mismatches < 40) $display("ERROR at %0t: %s", $time, what);
      mismatches++;
    endtask

    task check_result(qat_pkg::out_item_t got);
      qat_pkg::out_item_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected (kind %0d, char %02h)",
                                  got.kind, got.out_char));
        return;
      end
      want = expected_q.pop_front();
      if (got.kind !== want.kind)
        report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
      if (got.out_char !== want.out_char)
        report_mismatch($sformatf("out_char %02h, expected %02h", got.out_char, want.out_char));
      if (got.token_index !== want.token_index)
        report_mismatch($sformatf("token_index %0d, expected %0d",
                                  got.token_index, want.token_index));
      if (got.token_count !== want.token_count)
        report_mismatch($sformatf("token_count %0d, expected %0d",
                                  got.token_count, want.token_count));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  qat_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  qat_pkg::out_item_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [DATA_W-1:0] cfg_pwdata = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  token_scoreboard sb;
  qat_pkg::in_item_t line_bytes[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;

  quoted_argument_tokenizer dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #1 clk = ~clk;

  // Every accepted request on either channel goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) sb.note_byte(in_data);
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // Receiver: random stalls, plus one long hold-off when asked for.
  initial begin : receiver
    bit hold_seen;
    int hold_left;
    hold_seen = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Give up when nothing moves on any port for too long.
  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_psel && cfg_penable))
        stalled = 0;
      else
        stalled++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Offer one input request, with random idle cycles ahead of it.
  task automatic push_byte(qat_pkg::in_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic add_byte(logic [7:0] c, logic eol);
    qat_pkg::in_item_t item;
    item.ch = c;
    item.end_of_line = eol;
    line_bytes.push_back(item);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], 1'b0);
  endtask

  task automatic send_line();
    foreach (line_bytes[i]) push_byte(line_bytes[i]);
    line_bytes.delete();
  endtask

  // Wait until every expected result is in and the pipeline has settled.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write max_fields, then read it back.
  task automatic set_max_fields(logic [7:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= MAX_FIELDS_ADDR;
    cfg_pwdata <= DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.max_fields = value;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[7:0] !== value)
      sb.report_mismatch($sformatf("max_fields reads %02h, expected %02h",
                                   cfg_prdata[7:0], value));
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  function automatic logic [7:0] random_blank();
    case ($urandom_range(4))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_VTAB;
      3: return CH_FORMFEED;
      default: return CH_RETURN;
    endcase
  endfunction

  // A byte with no special meaning: printable, control or high.
  function automatic logic [7:0] random_plain();
    logic [7:0] c;
    case ($urandom_range(5))
      0: c = 8'($urandom_range(8'h80, 8'hFF));
      1: c = ($urandom_range(1) != 0) ? 8'($urandom_range(8'h01, 8'h08))
                                      : 8'($urandom_range(8'h0E, 8'h1F));
      default: begin
        do c = 8'($urandom_range(8'h21, 8'h7E));
        while (c == qat_pkg::CH_DQUOTE || c == qat_pkg::CH_SQUOTE ||
               c == qat_pkg::CH_BACKSLASH);
      end
    endcase
    return c;
  endfunction

  // A backslash and what it escapes.
  task automatic add_escape();
    add_byte(qat_pkg::CH_BACKSLASH, 1'b0);
    case ($urandom_range(5))
      0: add_byte(qat_pkg::CH_DQUOTE, 1'b0);
      1: add_byte(qat_pkg::CH_SQUOTE, 1'b0);
      2: add_byte(qat_pkg::CH_BACKSLASH, 1'b0);
      3: add_byte(random_blank(), 1'b0);
      4: add_byte(qat_pkg::CH_NEWLINE, 1'b0);
      default: add_byte(random_plain(), 1'b0);
    endcase
  endtask

  // Build one command line: mostly well formed, now and then pure noise.
  task automatic build_line(int max_tokens);
    int ntok;
    logic [7:0] q;
    qat_pkg::in_item_t tail;
    if ($urandom_range(7) == 0) begin
      repeat ($urandom_range(1, 12))
        add_byte(8'($urandom_range(255)), $urandom_range(5) == 0);
      return;
    end
    if ($urandom_range(3) == 0) add_byte(random_blank(), 1'b0);
    ntok = ($urandom_range(5) == 0) ? $urandom_range(0, max_tokens) : $urandom_range(0, 4);
    for (int t = 0; t < ntok; t++) begin
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(3))
          0, 1: add_byte(random_plain(), 1'b0);
          2: begin
            // Quoted stretch with literal blanks and the other quote kind.
            q = ($urandom_range(1) != 0) ? qat_pkg::CH_DQUOTE : qat_pkg::CH_SQUOTE;
            add_byte(q, 1'b0);
            repeat ($urandom_range(0, 4)) begin
              case ($urandom_range(3))
                0: add_byte(random_blank(), 1'b0);
                1: add_byte((q == qat_pkg::CH_DQUOTE) ? qat_pkg::CH_SQUOTE
                                                      : qat_pkg::CH_DQUOTE, 1'b0);
                2: add_escape();
                default: add_byte(random_plain(), 1'b0);
              endcase
            end
            if ($urandom_range(9) != 0) add_byte(q, 1'b0);
          end
          default: add_escape();
        endcase
      end
      if (t < ntok - 1) begin
        add_byte(($urandom_range(7) == 0) ? qat_pkg::CH_NEWLINE : random_blank(), 1'b0);
        if ($urandom_range(2) == 0) add_byte(random_blank(), 1'b0);
      end
    end
    // Line ending: zero byte, end flag, newline, or trailing backslash.
    case ($urandom_range(5))
      0, 1: add_byte(qat_pkg::CH_NUL, 1'b0);
      2: begin
        if (line_bytes.size() == 0) begin
          add_byte(qat_pkg::CH_NUL, 1'b1);
        end else begin
          tail = line_bytes.pop_back();
          tail.end_of_line = 1'b1;
          line_bytes.push_back(tail);
        end
      end
      3: begin
        add_byte(random_blank(), 1'b0);
        add_byte(qat_pkg::CH_NEWLINE, 1'b0);
        repeat ($urandom_range(0, 3)) add_byte(random_plain(), 1'b0);
        add_byte(qat_pkg::CH_NUL, 1'b0);
      end
      4: begin
        if ($urandom_range(1) != 0) begin
          add_byte(qat_pkg::CH_BACKSLASH, 1'b1);
        end else begin
          add_byte(qat_pkg::CH_BACKSLASH, 1'b0);
          add_byte(qat_pkg::CH_NUL, 1'b0);
        end
      end
      default: add_byte(random_blank(), 1'b1);
    endcase
  endtask

  // One random phase at a given idle pattern and field limit.
  task automatic run_phase(int send_pct, int recv_pct, logic [7:0] fields, bit squeeze);
    int start;
    bit squeezed;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    squeezed = 1'b0;
    set_max_fields(fields);
    start = sb.bytes_used;
    while (sb.bytes_used - start < PHASE_BYTES) begin
      if (squeeze && !squeezed && sb.bytes_used - start > 40) begin
        hold_req = ~hold_req;
        squeezed = 1'b1;
      end
      build_line((fields >= 8'd20) ? 20 : int'(fields) + 1);
      send_line();
    end
    drain();
  endtask

  initial begin
    sb = new();
    send_idle_pct = 9;
    recv_idle_pct = 67;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Quotes, every escape kind, newline closing a token, high byte,
    // and a trailing backslash on the flagged last byte.
    add_text("a\" '\"\\\"\\\\\\ \\q'\"'");
    add_byte(qat_pkg::CH_NEWLINE, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(qat_pkg::CH_BACKSLASH, 1'b1);
    // Newline between tokens ends the line; the rest is skipped.
    add_byte(qat_pkg::CH_NEWLINE, 1'b0);
    add_byte("z", 1'b0);
    add_byte(qat_pkg::CH_NUL, 1'b0);
    // Trailing backslash before the zero byte.
    add_byte(qat_pkg::CH_BACKSLASH, 1'b0);
    add_byte(qat_pkg::CH_NUL, 1'b0);
    send_line();
    drain();

    // Overflow at token start with a single slot.
    set_max_fields(8'd1);
    add_text("a b");
    add_byte(CH_TAB, 1'b1);
    send_line();
    drain();

    // With no slots even an empty line overflows.
    set_max_fields(8'd0);
    add_byte(qat_pkg::CH_NUL, 1'b0);
    send_line();
    drain();

    run_phase(9, 67, 8'd255, 1'b0);
    run_phase(67, 9, 8'($urandom_range(2, 6)), 1'b0);
    run_phase(0, 0, 8'd3, 1'b1);

    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
